FILE: rtl/pru_pkg.sv
// types, codes and the paeth predictor shared by the row unfilter
package pru_pkg;

    localparam logic [1:0] REG_WIDTH_PX    = 2'd0;
    localparam logic [1:0] REG_HEIGHT_ROWS = 2'd1;
    localparam logic [1:0] REG_CHANNELS    = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [2:0] CH_RGB = 3'd3;

    typedef struct packed {
        logic       is_filter;
        logic       emit;
        logic       bad;
        logic       row_end;
        logic       image_end;
        logic       b_valid;
        logic [2:0] filter;
        logic [7:0] data;
    } tok_t;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] pa_s;
        logic signed [10:0] pb_s;
        logic signed [10:0] pc_s;
        logic [10:0] pa;
        logic [10:0] pb;
        logic [10:0] pc;
        pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
        pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
        pc_s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = pa_s[10] ? 11'(-pa_s) : 11'(pa_s);
        pb = pb_s[10] ? 11'(-pb_s) : 11'(pb_s);
        pc = pc_s[10] ? 11'(-pc_s) : 11'(pc_s);
        if (pa <= pb && pa <= pc)
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

endpackage

FILE: rtl/png_row_unfilter.sv
// png scanline unfilter: byte stream in, reconstructed rgb/rgba bytes out
//
// input stream s_axis carries the inflated image one byte per beat: each row
// is a filter type byte followed by width_px * channels filtered bytes.
// output stream m_axis carries one reconstructed byte per data beat, with
// tlast on the last byte of a row and tuser[0] on the last byte of the image.
// a filter type above 4 gives a single beat with tuser[1] set and zero data;
// the rest of that image is swallowed, and the error clears at image end.
// the cfg channel writes width_px, height_rows and channels; it is always
// ready; it is to be written only between images, and the block does not enforce this.
// an input beat passes the line store read stage, then prediction into the
// output register.
// throughput, one byte per cycle unless m_axis stalls, is set by the line
// store: one port per side, read at input, written as the read stage moves.
// reset clears all control state and the histories; the line store is not
// cleared, as row 0 ignores what it reads.
// when m_axis stalls the output register and the read stage hold, and
// s_axis_tready drops once both are full.
module png_row_unfilter
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // end_of_image, bad_filter
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int COL_W = (MAX_ROW_BYTES > 2) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LEN_W = ($clog2(MAX_ROW_BYTES + 1) > 10) ? $clog2(MAX_ROW_BYTES + 1) : 10;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_BYTES);

    logic [7:0]  width_reg;
    logic [12:0] height_reg;
    logic [2:0]  channels_reg;

    logic [COL_W-1:0] col_reg;
    logic [11:0]      row_reg;
    logic             awaiting_reg;
    logic [2:0]       filter_reg;
    logic             err_reg;

    logic             s1_valid_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [COL_W-1:0] s1_col_reg;
    logic [7:0]       rdata_reg;

    logic [7:0] left_reg [4];
    logic [7:0] upleft_reg [4];

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic [1:0] out_user_reg;

    logic [7:0] line_mem [MAX_ROW_BYTES];

    logic             ch3;
    logic [7:0]       w_eff;
    logic [9:0]       n10;
    logic [LEN_W-1:0] n_ext;
    logic [LEN_W-1:0] line_len;
    logic [12:0]      h_eff;
    logic             row_end;
    logic             image_end;
    logic             s_fire;
    logic             s1_adv;
    logic             mem_we;
    logic             mem_re;
    logic [1:0]       hidx;
    logic [7:0]       a_val;
    logic [7:0]       b_val;
    logic [7:0]       c_val;
    logic [7:0]       pred;
    logic [7:0]       val;
    logic [8:0]       avg_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 8'd1;
            height_reg   <= 13'd1;
            channels_reg <= 3'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH_PX:    width_reg    <= cfg_data[7:0];
                REG_HEIGHT_ROWS: height_reg   <= cfg_data;
                REG_CHANNELS:    channels_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // effective geometry
    assign ch3   = (channels_reg == CH_RGB);
    assign w_eff = (width_reg == 8'd0) ? 8'd1 : ((width_reg > 8'd128) ? 8'd128 : width_reg);
    assign n10   = ch3 ? ({1'b0, w_eff, 1'b0} + {2'b00, w_eff}) : {w_eff, 2'b00};
    assign n_ext = LEN_W'(n10);
    assign line_len = (n_ext > MAX_LEN) ? MAX_LEN : n_ext;
    assign h_eff = (height_reg == 13'd0) ? 13'd1
                 : ((height_reg > 13'd4096) ? 13'd4096 : height_reg);

    assign row_end   = (LEN_W'(col_reg) + LEN_W'(1)) >= line_len;
    assign image_end = row_end && (({1'b0, row_reg} + 13'd1) >= h_eff);

    // handshake
    assign s1_adv        = !tok_reg.emit || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign mem_re        = s_fire && !awaiting_reg;
    assign mem_we        = s1_valid_reg && s1_adv && !tok_reg.is_filter;

    always_comb
    begin
        tok_next           = '0;
        tok_next.data      = s_axis_tdata;
        tok_next.is_filter = awaiting_reg;
        if (awaiting_reg)
        begin
            tok_next.bad  = !err_reg && (s_axis_tdata > {5'd0, FILT_PAETH});
            tok_next.emit = !err_reg && (s_axis_tdata > {5'd0, FILT_PAETH});
        end
        else
        begin
            tok_next.emit      = !err_reg;
            tok_next.row_end   = row_end;
            tok_next.image_end = image_end;
            tok_next.b_valid   = (row_reg != 12'd0);
            tok_next.filter    = filter_reg;
        end
    end

    // row and column sequencing at the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            awaiting_reg <= 1'b1;
            filter_reg   <= FILT_NONE;
            err_reg      <= 1'b0;
        end
        else if (s_fire)
        begin
            if (awaiting_reg)
            begin
                awaiting_reg <= 1'b0;
                col_reg      <= '0;
                if (!err_reg)
                begin
                    if (s_axis_tdata > {5'd0, FILT_PAETH})
                    begin
                        err_reg    <= 1'b1;
                        filter_reg <= FILT_NONE;
                    end
                    else
                    begin
                        filter_reg <= s_axis_tdata[2:0];
                    end
                end
            end
            else if (image_end)
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                awaiting_reg <= 1'b1;
                filter_reg   <= FILT_NONE;
                err_reg      <= 1'b0;
            end
            else if (row_end)
            begin
                row_reg      <= row_reg + 12'd1;
                awaiting_reg <= 1'b1;
                col_reg      <= '0;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tok_reg      <= '0;
        end
        else if (s_fire)
        begin
            s1_valid_reg <= 1'b1;
            tok_reg      <= tok_next;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
            tok_reg      <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_col_reg <= col_reg;
        end
    end

    // line store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[s1_col_reg] <= val;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[col_reg];
        end
    end

    // prediction
    assign hidx    = ch3 ? 2'd2 : 2'd3;
    assign a_val   = left_reg[hidx];
    assign c_val   = upleft_reg[hidx];
    assign b_val   = tok_reg.b_valid ? rdata_reg : 8'd0;
    assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

    always_comb
    begin
        case (tok_reg.filter)
            FILT_SUB:   pred = a_val;
            FILT_UP:    pred = b_val;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(a_val, b_val, c_val);
            default:    pred = 8'd0;
        endcase
    end

    assign val = tok_reg.data + pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end
        else if (s1_valid_reg && s1_adv)
        begin
            if (tok_reg.is_filter)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    left_reg[i]   <= 8'd0;
                    upleft_reg[i] <= 8'd0;
                end
            end
            else
            begin
                for (int i = 3; i > 0; i--)
                begin
                    left_reg[i]   <= left_reg[i-1];
                    upleft_reg[i] <= upleft_reg[i-1];
                end
                left_reg[0]   <= val;
                upleft_reg[0] <= b_val;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_adv && tok_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv && tok_reg.emit)
        begin
            out_data_reg <= tok_reg.is_filter ? 8'd0 : val;
            out_last_reg <= tok_reg.row_end;
            out_user_reg <= {tok_reg.bad, tok_reg.image_end};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> s1_col_reg != col_reg)
        else $error("line store read and write hit the same column");

    a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'd0 && !m_axis_tlast
                                            && !m_axis_tuser[0])
        else $error("error beat carries data or end flags");

    a_row_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !awaiting_reg && row_end |=> awaiting_reg)
        else $error("no filter byte expected after end of row");

    a_filter_tok: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && tok_reg.is_filter |-> !tok_reg.row_end && !tok_reg.image_end
                                              && (tok_reg.emit == tok_reg.bad))
        else $error("filter byte token carries data flags");

endmodule
